>>> sv/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define VRAP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds while reset is held
`define VRAP_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/vrap_pkg.sv
// constants, tables and widths shared by the rotate-about-point block
`timescale 1ns / 1ps

package vrap_pkg;

  // parameter defaults
  localparam int COORD_WIDTH_DEF    = 32;
  localparam int ROTATION_STEPS_DEF = 18;

  // fixed field and datapath widths
  localparam int ANGLE_W = 18;
  localparam int TRIG_W  = 33;
  localparam int Z_W     = 33;

  // angle units: 1/256 degree
  localparam int FULL_TURN    = 92160;
  localparam int HALF_TURN    = 46080;
  localparam int QUARTER_TURN = 23040;

  // units to Q2.30 radians, scaled by 2^8
  localparam int UNITS_TO_RAD_Q38 = 18740330;
  localparam int UNITS_RAD_W      = 25;

  // 1/gain of the cordic in Q2.30
  localparam int INV_GAIN_Q30 = 652032874;

  // atan(2^-i) in Q2.30, truncated
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
    32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
    32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
    32'd262143,    32'd131071,    32'd65535,     32'd32767,
    32'd16383,     32'd8191,      32'd4095,      32'd2047,
    32'd1023,      32'd511,       32'd255,       32'd127,
    32'd63,        32'd31,        32'd15,        32'd7,
    32'd3,         32'd1,         32'd0,         32'd0
  };

endpackage

>>> sv/vrap_prep.sv
// front pipeline: offset from centre, angle reduction and conversion to radians
`timescale 1ns / 1ps

module vrap_prep #(
  parameter int COORD_WIDTH = vrap_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]       point_x_i,
  input  logic signed [COORD_WIDTH-1:0]       point_y_i,
  input  logic signed [COORD_WIDTH-1:0]       center_x_i,
  input  logic signed [COORD_WIDTH-1:0]       center_y_i,
  input  logic signed [vrap_pkg::ANGLE_W-1:0] angle_units_i,
  input  logic                                turn_clockwise_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [COORD_WIDTH:0]         dx_o,
  output logic signed [COORD_WIDTH:0]         dy_o,
  output logic signed [COORD_WIDTH-1:0]       cx_o,
  output logic signed [COORD_WIDTH-1:0]       cy_o,
  output logic                                flip_o,
  output logic signed [vrap_pkg::Z_W-1:0]     z_o
);
  import vrap_pkg::*;

  localparam int NST   = 4;
  localparam int DW    = COORD_WIDTH + 1;
  localparam int AN_W  = ANGLE_W + 1;
  localparam int R_W   = 16;
  localparam int MAG_W = R_W - 1;
  localparam int P_W   = MAG_W + UNITS_RAD_W;

  localparam logic signed [AN_W-1:0] FULL_A    = AN_W'(FULL_TURN);
  localparam logic signed [AN_W-1:0] HALF_A    = AN_W'(HALF_TURN);
  localparam logic signed [AN_W-1:0] QUARTER_A = AN_W'(QUARTER_TURN);
  localparam logic [P_W-1:0]         UNITS_P   = P_W'(UNITS_TO_RAD_Q38);
  localparam logic [P_W-1:0]         HALF_LSB  = P_W'(128);

  logic [NST-1:0] v_q, v_d, rdy;

  logic signed [DW-1:0]          dx_q [NST];
  logic signed [DW-1:0]          dy_q [NST];
  logic signed [COORD_WIDTH-1:0] cx_q [NST];
  logic signed [COORD_WIDTH-1:0] cy_q [NST];

  logic signed [DW-1:0]   dx_d, dy_d;
  logic signed [AN_W-1:0] a_ext, an_d, an_s0_q;
  logic signed [AN_W-1:0] red, fold;
  logic signed [R_W-1:0]  r_d, r_s1_q;
  logic                   flip_d, flip_s1_q, flip_s2_q, flip_s3_q;
  logic signed [R_W-1:0]  r_abs;
  logic [MAG_W-1:0]       mag;
  logic [P_W-1:0]         prod_d, prod_s2_q;
  logic                   neg_s2_q;
  logic signed [Z_W-1:0]  zm, z_d, z_s3_q;

  // stage ready: a stage takes a beat when empty or when it empties itself
  for (genvar k = 0; k < NST - 1; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign rdy[NST-1] = !v_q[NST-1] || out_ready_i;
  assign v_d        = (rdy & {v_q[NST-2:0], in_valid_i}) | (~rdy & v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // stage 0: offsets at full width, direction applied to the angle
  always_comb begin
    dx_d  = {point_x_i[COORD_WIDTH-1], point_x_i} - {center_x_i[COORD_WIDTH-1], center_x_i};
    dy_d  = {point_y_i[COORD_WIDTH-1], point_y_i} - {center_y_i[COORD_WIDTH-1], center_y_i};
    a_ext = {angle_units_i[ANGLE_W-1], angle_units_i};
    an_d  = turn_clockwise_i ? a_ext : -a_ext;
  end

  // stage 1: reduce into one turn, then fold into a half turn
  always_comb begin
    if (an_s0_q >= HALF_A) begin
      red = an_s0_q - FULL_A;
    end else if (an_s0_q < -HALF_A) begin
      red = an_s0_q + FULL_A;
    end else begin
      red = an_s0_q;
    end
    flip_d = 1'b0;
    fold   = red;
    if (red > QUARTER_A) begin
      fold   = red - HALF_A;
      flip_d = 1'b1;
    end else if (red < -QUARTER_A) begin
      fold   = red + HALF_A;
      flip_d = 1'b1;
    end
    r_d = signed'(fold[R_W-1:0]);
  end

  // stage 2: magnitude times the radian scale, rounding half up
  always_comb begin
    r_abs  = r_s1_q[R_W-1] ? -r_s1_q : r_s1_q;
    mag    = r_abs[MAG_W-1:0];
    prod_d = P_W'(mag) * UNITS_P + HALF_LSB;
  end

  // stage 3: scale down and restore the sign
  always_comb begin
    zm  = signed'({{(Z_W - (P_W - 8)){1'b0}}, prod_s2_q[P_W-1:8]});
    z_d = neg_s2_q ? -zm : zm;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      dx_q[0] <= dx_d;
      dy_q[0] <= dy_d;
      cx_q[0] <= center_x_i;
      cy_q[0] <= center_y_i;
      an_s0_q <= an_d;
    end
    if (rdy[1]) begin
      r_s1_q    <= r_d;
      flip_s1_q <= flip_d;
    end
    if (rdy[2]) begin
      prod_s2_q <= prod_d;
      neg_s2_q  <= r_s1_q[R_W-1];
      flip_s2_q <= flip_s1_q;
    end
    if (rdy[3]) begin
      z_s3_q    <= z_d;
      flip_s3_q <= flip_s2_q;
    end
  end

  // coordinate payload rides alongside
  for (genvar k = 1; k < NST; k++) begin : g_pay
    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        dx_q[k] <= dx_q[k-1];
        dy_q[k] <= dy_q[k-1];
        cx_q[k] <= cx_q[k-1];
        cy_q[k] <= cy_q[k-1];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NST-1];
  assign dx_o        = dx_q[NST-1];
  assign dy_o        = dy_q[NST-1];
  assign cx_o        = cx_q[NST-1];
  assign cy_o        = cy_q[NST-1];
  assign flip_o      = flip_s3_q;
  assign z_o         = z_s3_q;

endmodule

>>> sv/vrap_cell.sv
// one cordic rotation step, holding its vector, residual angle and payload
`timescale 1ns / 1ps

module vrap_cell #(
  parameter int STEP        = 0,
  parameter int COORD_WIDTH = vrap_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [vrap_pkg::TRIG_W-1:0] x_i,
  input  logic signed [vrap_pkg::TRIG_W-1:0] y_i,
  input  logic signed [vrap_pkg::Z_W-1:0]    z_i,
  input  logic signed [COORD_WIDTH:0]        dx_i,
  input  logic signed [COORD_WIDTH:0]        dy_i,
  input  logic signed [COORD_WIDTH-1:0]      cx_i,
  input  logic signed [COORD_WIDTH-1:0]      cy_i,
  input  logic                               flip_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [vrap_pkg::TRIG_W-1:0] x_o,
  output logic signed [vrap_pkg::TRIG_W-1:0] y_o,
  output logic signed [vrap_pkg::Z_W-1:0]    z_o,
  output logic signed [COORD_WIDTH:0]        dx_o,
  output logic signed [COORD_WIDTH:0]        dy_o,
  output logic signed [COORD_WIDTH-1:0]      cx_o,
  output logic signed [COORD_WIDTH-1:0]      cy_o,
  output logic                               flip_o
);
  import vrap_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN_K = signed'({{(Z_W - 32){1'b0}}, ATAN_Q30[STEP]});

  logic                       valid_q, ready;
  logic signed [TRIG_W-1:0]   xs, ys, x_d, y_d, x_q, y_q;
  logic signed [Z_W-1:0]      z_d, z_q;
  logic signed [COORD_WIDTH:0]   dx_q, dy_q;
  logic signed [COORD_WIDTH-1:0] cx_q, cy_q;
  logic                       flip_q;

  assign ready = !valid_q || out_ready_i;

  // micro-rotation towards zero residual angle
  always_comb begin
    xs = x_i >>> STEP;
    ys = y_i >>> STEP;
    if (!z_i[Z_W-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN_K;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN_K;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      dx_q   <= dx_i;
      dy_q   <= dy_i;
      cx_q   <= cx_i;
      cy_q   <= cy_i;
      flip_q <= flip_i;
    end
  end

  assign in_ready_o  = ready;
  assign out_valid_o = valid_q;
  assign x_o         = x_q;
  assign y_o         = y_q;
  assign z_o         = z_q;
  assign dx_o        = dx_q;
  assign dy_o        = dy_q;
  assign cx_o        = cx_q;
  assign cy_o        = cy_q;
  assign flip_o      = flip_q;

endmodule

>>> sv/vrap_post.sv
// back pipeline: offset times cos and sin, centre added back, saturation
`timescale 1ns / 1ps

module vrap_post #(
  parameter int COORD_WIDTH = vrap_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [vrap_pkg::TRIG_W-1:0] cos_i,
  input  logic signed [vrap_pkg::TRIG_W-1:0] sin_i,
  input  logic signed [COORD_WIDTH:0]        dx_i,
  input  logic signed [COORD_WIDTH:0]        dy_i,
  input  logic signed [COORD_WIDTH-1:0]      cx_i,
  input  logic signed [COORD_WIDTH-1:0]      cy_i,
  input  logic                               flip_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [COORD_WIDTH-1:0]      rotated_x_o,
  output logic signed [COORD_WIDTH-1:0]      rotated_y_o
);
  import vrap_pkg::*;

  localparam int NST    = 5;
  localparam int DW     = COORD_WIDTH + 1;
  localparam int LO     = DW / 2;
  localparam int HI     = DW - LO;
  localparam int FULL_W = DW + TRIG_W + 1;
  localparam int PM_W   = FULL_W - 30;
  localparam int PS_W   = PM_W + 1;
  localparam int SUM_W  = PS_W + 2;

  localparam logic [FULL_W-1:0]       ROUND_HALF = FULL_W'(1) << 29;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    signed'({{(SUM_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}});
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  logic [NST-1:0] v_q, v_d, rdy;

  logic signed [COORD_WIDTH-1:0] cx_q [3];
  logic signed [COORD_WIDTH-1:0] cy_q [3];

  // stage 0 signals
  logic              c_neg, s_neg, dx_neg, dy_neg;
  logic signed [TRIG_W-1:0] c_abs, s_abs;
  logic signed [DW-1:0]     dx_abs, dy_abs;
  logic [DW-1:0]     dxm_q, dym_q;
  logic [TRIG_W-1:0] cm_q, sm_q;
  logic [3:0]        neg_d, neg_s0_q, neg_s1_q;

  // lanes: x*cos, y*sin, x*sin, y*cos
  logic [DW-1:0]        am [4];
  logic [TRIG_W-1:0]    tm [4];
  logic [LO+TRIG_W-1:0] pl_q [4];
  logic [HI+TRIG_W-1:0] ph_q [4];
  logic [FULL_W-1:0]    pf   [4];
  logic signed [PS_W-1:0] ps_d [4];
  logic signed [PS_W-1:0] ps_q [4];

  logic signed [SUM_W-1:0]       sx_d, sy_d, sx_q, sy_q;
  logic signed [COORD_WIDTH-1:0] rx_d, ry_d, rx_q, ry_q;

  for (genvar k = 0; k < NST - 1; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign rdy[NST-1] = !v_q[NST-1] || out_ready_i;
  assign v_d        = (rdy & {v_q[NST-2:0], in_valid_i}) | (~rdy & v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // stage 0: sign and magnitude of each factor, half-turn flip folded into signs
  always_comb begin
    dx_neg = dx_i[DW-1];
    dy_neg = dy_i[DW-1];
    c_neg  = cos_i[TRIG_W-1] ^ flip_i;
    s_neg  = sin_i[TRIG_W-1] ^ flip_i;
    dx_abs = dx_neg ? -dx_i : dx_i;
    dy_abs = dy_neg ? -dy_i : dy_i;
    c_abs  = cos_i[TRIG_W-1] ? -cos_i : cos_i;
    s_abs  = sin_i[TRIG_W-1] ? -sin_i : sin_i;
    neg_d  = {dy_neg ^ c_neg, dx_neg ^ s_neg, dy_neg ^ s_neg, dx_neg ^ c_neg};
  end

  always_comb begin
    am[0] = dxm_q;
    tm[0] = cm_q;
    am[1] = dym_q;
    tm[1] = sm_q;
    am[2] = dxm_q;
    tm[2] = sm_q;
    am[3] = dym_q;
    tm[3] = cm_q;
  end

  for (genvar j = 0; j < 4; j++) begin : g_lane
    // stage 2: join partial products, round half away from zero
    always_comb begin
      pf[j]   = (FULL_W'(ph_q[j]) << LO) + FULL_W'(pl_q[j]) + ROUND_HALF;
      ps_d[j] = neg_s1_q[j] ? -signed'({1'b0, pf[j][FULL_W-1:30]})
                            :  signed'({1'b0, pf[j][FULL_W-1:30]});
    end

    // stage 1: split products of the magnitudes
    always_ff @(posedge clk_i) begin
      if (rdy[1]) begin
        pl_q[j] <= (LO+TRIG_W)'(am[j][LO-1:0]) * (LO+TRIG_W)'(tm[j]);
        ph_q[j] <= (HI+TRIG_W)'(am[j][DW-1:LO]) * (HI+TRIG_W)'(tm[j]);
      end
      if (rdy[2]) begin
        ps_q[j] <= ps_d[j];
      end
    end
  end

  // stage 3: sums with the centre added back
  always_comb begin
    sx_d = SUM_W'(ps_q[0]) - SUM_W'(ps_q[1]) + SUM_W'(cx_q[2]);
    sy_d = SUM_W'(ps_q[2]) + SUM_W'(ps_q[3]) + SUM_W'(cy_q[2]);
  end

  // stage 4: clamp to the coordinate range
  always_comb begin
    if (sx_q > SAT_HI) begin
      rx_d = signed'(SAT_HI[COORD_WIDTH-1:0]);
    end else if (sx_q < SAT_LO) begin
      rx_d = signed'(SAT_LO[COORD_WIDTH-1:0]);
    end else begin
      rx_d = signed'(sx_q[COORD_WIDTH-1:0]);
    end
    if (sy_q > SAT_HI) begin
      ry_d = signed'(SAT_HI[COORD_WIDTH-1:0]);
    end else if (sy_q < SAT_LO) begin
      ry_d = signed'(SAT_LO[COORD_WIDTH-1:0]);
    end else begin
      ry_d = signed'(sy_q[COORD_WIDTH-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      dxm_q    <= dx_abs;
      dym_q    <= dy_abs;
      cm_q     <= c_abs;
      sm_q     <= s_abs;
      neg_s0_q <= neg_d;
      cx_q[0]  <= cx_i;
      cy_q[0]  <= cy_i;
    end
    if (rdy[1]) begin
      neg_s1_q <= neg_s0_q;
      cx_q[1]  <= cx_q[0];
      cy_q[1]  <= cy_q[0];
    end
    if (rdy[2]) begin
      cx_q[2] <= cx_q[1];
      cy_q[2] <= cy_q[1];
    end
    if (rdy[3]) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
    end
    if (rdy[4]) begin
      rx_q <= rx_d;
      ry_q <= ry_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NST-1];
  assign rotated_x_o = rx_q;
  assign rotated_y_o = ry_q;

endmodule

>>> sv/vector_rotate_about_point.sv
// top level: rotation of a point about a centre through a row of cordic cells
//
//  channel   dir  data                                        sideband
//  s_axis    in   point_x, point_y, center_x, center_y, angle  tuser: turn_clockwise
//  m_axis    out  rotated_x, rotated_y                         -
//
// one beat per cycle sustained while m_axis_tready_i is high; an input beat
// passes through 4 front stages, one cordic cell per step and 5 back stages
// every stage takes a beat when it is empty or passes its own on, so bubbles
// close up and input is taken while a result waits at the output register
// reset clears the stage valid flags only; no clearing pass
`timescale 1ns / 1ps

module vector_rotate_about_point #(
  parameter int COORD_WIDTH    = vrap_pkg::COORD_WIDTH_DEF,
  parameter int ROTATION_STEPS = vrap_pkg::ROTATION_STEPS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // point_x, point_y, center_x, center_y, angle_units, zero fill
  input  logic [8*((4*COORD_WIDTH+vrap_pkg::ANGLE_W+7)/8)-1:0] s_axis_tdata_i,
  // turn_clockwise
  input  logic s_axis_tuser_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // rotated_x, rotated_y, zero fill
  output logic [8*((2*COORD_WIDTH+7)/8)-1:0] m_axis_tdata_o
);
  import vrap_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam logic signed [TRIG_W-1:0] X_INIT = TRIG_W'(INV_GAIN_Q30);

  logic signed [COORD_WIDTH-1:0] point_x, point_y, center_x, center_y;
  logic signed [ANGLE_W-1:0]     angle_units;
  logic signed [COORD_WIDTH-1:0] rotated_x, rotated_y;

  // links along the cell row, index 0 fed by the front stages
  logic [ROTATION_STEPS:0]       c_valid, c_ready;
  logic signed [TRIG_W-1:0]      c_x  [ROTATION_STEPS+1];
  logic signed [TRIG_W-1:0]      c_y  [ROTATION_STEPS+1];
  logic signed [Z_W-1:0]         c_z  [ROTATION_STEPS+1];
  logic signed [DW-1:0]          c_dx [ROTATION_STEPS+1];
  logic signed [DW-1:0]          c_dy [ROTATION_STEPS+1];
  logic signed [COORD_WIDTH-1:0] c_cx [ROTATION_STEPS+1];
  logic signed [COORD_WIDTH-1:0] c_cy [ROTATION_STEPS+1];
  logic [ROTATION_STEPS:0]       c_flip;

  // input beat fields
  assign point_x     = s_axis_tdata_i[COORD_WIDTH-1:0];
  assign point_y     = s_axis_tdata_i[2*COORD_WIDTH-1:COORD_WIDTH];
  assign center_x    = s_axis_tdata_i[3*COORD_WIDTH-1:2*COORD_WIDTH];
  assign center_y    = s_axis_tdata_i[4*COORD_WIDTH-1:3*COORD_WIDTH];
  assign angle_units = s_axis_tdata_i[4*COORD_WIDTH+ANGLE_W-1:4*COORD_WIDTH];

  vrap_prep #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_prep (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid_i),
    .in_ready_o      (s_axis_tready_o),
    .point_x_i       (point_x),
    .point_y_i       (point_y),
    .center_x_i      (center_x),
    .center_y_i      (center_y),
    .angle_units_i   (angle_units),
    .turn_clockwise_i(s_axis_tuser_i),
    .out_valid_o     (c_valid[0]),
    .out_ready_i     (c_ready[0]),
    .dx_o            (c_dx[0]),
    .dy_o            (c_dy[0]),
    .cx_o            (c_cx[0]),
    .cy_o            (c_cy[0]),
    .flip_o          (c_flip[0]),
    .z_o             (c_z[0])
  );

  // cordic start vector
  assign c_x[0] = X_INIT;
  assign c_y[0] = '0;

  // row of rotation cells
  for (genvar g = 0; g < ROTATION_STEPS; g++) begin : g_cell
    vrap_cell #(
      .STEP       (g),
      .COORD_WIDTH(COORD_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (c_valid[g]),
      .in_ready_o (c_ready[g]),
      .x_i        (c_x[g]),
      .y_i        (c_y[g]),
      .z_i        (c_z[g]),
      .dx_i       (c_dx[g]),
      .dy_i       (c_dy[g]),
      .cx_i       (c_cx[g]),
      .cy_i       (c_cy[g]),
      .flip_i     (c_flip[g]),
      .out_valid_o(c_valid[g+1]),
      .out_ready_i(c_ready[g+1]),
      .x_o        (c_x[g+1]),
      .y_o        (c_y[g+1]),
      .z_o        (c_z[g+1]),
      .dx_o       (c_dx[g+1]),
      .dy_o       (c_dy[g+1]),
      .cx_o       (c_cx[g+1]),
      .cy_o       (c_cy[g+1]),
      .flip_o     (c_flip[g+1])
    );
  end

  vrap_post #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_post (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (c_valid[ROTATION_STEPS]),
    .in_ready_o (c_ready[ROTATION_STEPS]),
    .cos_i      (c_x[ROTATION_STEPS]),
    .sin_i      (c_y[ROTATION_STEPS]),
    .dx_i       (c_dx[ROTATION_STEPS]),
    .dy_i       (c_dy[ROTATION_STEPS]),
    .cx_i       (c_cx[ROTATION_STEPS]),
    .cy_i       (c_cy[ROTATION_STEPS]),
    .flip_i     (c_flip[ROTATION_STEPS]),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .rotated_x_o(rotated_x),
    .rotated_y_o(rotated_y)
  );

  // output beat packing
  always_comb begin
    m_axis_tdata_o                                = '0;
    m_axis_tdata_o[COORD_WIDTH-1:0]               = rotated_x;
    m_axis_tdata_o[2*COORD_WIDTH-1:COORD_WIDTH]   = rotated_y;
  end

endmodule

>>> sv/vrap_checker.sv
// port-level checks for the rotate-about-point block, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vrap_checker #(
  parameter int COORD_WIDTH    = vrap_pkg::COORD_WIDTH_DEF,
  parameter int ROTATION_STEPS = vrap_pkg::ROTATION_STEPS_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid_i,
  input logic s_axis_tready_o,
  input logic m_axis_tvalid_o,
  input logic m_axis_tready_i,
  input logic [8*((2*COORD_WIDTH+7)/8)-1:0] m_axis_tdata_o
);
  import vrap_pkg::*;

  // beats the pipeline can hold at once
  localparam int DEPTH = ROTATION_STEPS + 9;
  localparam int CNT_W = $clog2(DEPTH + 2) + 1;

  logic             in_beat, out_beat;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_beat = m_axis_tvalid_o && m_axis_tready_i;

  // beats in flight
  always_comb begin
    cnt_d = cnt_q;
    if (in_beat && !out_beat) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (out_beat && !in_beat) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `VRAP_ASSERT(result_held_on_stall, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "result changed while stalled")
  `VRAP_ASSERT(input_open_when_output_free, clk_i, rst_ni, (!m_axis_tvalid_o || m_axis_tready_i) |-> s_axis_tready_o, "input stalled with a free output")
  `VRAP_ASSERT(occupancy_bounded, clk_i, rst_ni, cnt_q <= CNT_W'(DEPTH), "more beats in flight than stages")
  `VRAP_ASSERT(no_result_without_beat, clk_i, rst_ni, m_axis_tvalid_o |-> cnt_q != '0, "result with no beat in flight")
  `VRAP_ASSERT_RST(quiet_in_reset, clk_i, !rst_ni |-> !m_axis_tvalid_o, "output valid during reset")

endmodule

bind vector_rotate_about_point vrap_checker #(
  .COORD_WIDTH   (COORD_WIDTH),
  .ROTATION_STEPS(ROTATION_STEPS)
) u_vrap_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);

>>> tb/vector_rotate_about_point_test.sv
// self-checking stream testbench for the rotate-about-point block
`timescale 1ns / 1ps

module vector_rotate_about_point_test;

  localparam int CW_BITS  = vrap_pkg::COORD_WIDTH_DEF;
  localparam int ANG_BITS = vrap_pkg::ANGLE_W;
  localparam int IN_W     = 8 * ((4 * CW_BITS + ANG_BITS + 7) / 8);
  localparam int OUT_W    = 8 * ((2 * CW_BITS + 7) / 8);

  // angle units are 1/256 degree
  localparam longint TURN    = 92160;
  localparam longint HALF    = 46080;
  localparam longint QUARTER = 23040;
  // radians per unit in Q2.30, scaled up by 2^8
  localparam longint UNIT_RAD_Q38 = 18740330;
  // cordic start vector, 1/gain in Q2.30
  localparam longint GAIN_INV_Q30 = 652032874;
  localparam int     STEPS        = 18;
  localparam longint ARC_STEP [STEPS] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191
  };

  localparam int RANDOM_POINTS = 1850;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_AT       = 600;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 40;

  typedef logic signed [CW_BITS-1:0]  coord_t;
  typedef logic signed [ANG_BITS-1:0] angle_t;
  typedef struct packed {
    coord_t y;
    coord_t x;
  } point_t;

  localparam coord_t COORD_MAX = 32'sh7fff_ffff;
  localparam coord_t COORD_MIN = 32'sh8000_0000;

  // expected rotated points, checked in order of arrival
  class rotation_scoreboard;
    point_t      awaited_points[$];
    int unsigned mismatches;
    int unsigned results_seen;

    // (a * t) / 2^30, rounded half away from zero
    function longint scale_q30(longint a, longint t);
      bit          neg;
      bit [95:0]   mag_a;
      bit [95:0]   mag_t;
      bit [95:0]   prod;
      neg   = (a < 0) != (t < 0);
      mag_a = (a < 0) ? -a : a;
      mag_t = (t < 0) ? -t : t;
      prod  = (mag_a * mag_t + 96'd536870912) >> 30;
      return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function coord_t clamp_coord(longint v);
      if (v > longint'(COORD_MAX)) return COORD_MAX;
      if (v < longint'(COORD_MIN)) return COORD_MIN;
      return coord_t'(v);
    endfunction

    function point_t rotate_about_centre(coord_t px, coord_t py, coord_t cx, coord_t cy,
                                         angle_t ang, logic cw);
      longint r;
      longint mag;
      longint z;
      longint cs;
      longint sn;
      longint xs;
      longint ys;
      longint dx;
      longint dy;
      bit     flip;
      int     i;
      point_t res;
      // counter-clockwise is the negated angle
      r = cw ? longint'(ang) : -longint'(ang);
      r = r % TURN;
      if (r < 0) r += TURN;
      if (r >= HALF) r -= TURN;
      // fold into +-90 degrees, flipping the sign of both terms
      flip = 1'b0;
      if (r > QUARTER) begin
        r -= HALF;
        flip = 1'b1;
      end else if (r < -QUARTER) begin
        r += HALF;
        flip = 1'b1;
      end
      mag = (r < 0) ? -r : r;
      z = (mag * UNIT_RAD_Q38 + 128) >>> 8;
      if (r < 0) z = -z;
      // rotation-mode cordic with floor shifts
      cs = GAIN_INV_Q30;
      sn = 0;
      for (i = 0; i < STEPS; i++) begin
        xs = cs >>> i;
        ys = sn >>> i;
        if (z >= 0) begin
          cs -= ys;
          sn += xs;
          z  -= ARC_STEP[i];
        end else begin
          cs += ys;
          sn -= xs;
          z  += ARC_STEP[i];
        end
      end
      if (flip) begin
        cs = -cs;
        sn = -sn;
      end
      // offset kept at full width, only the final sum saturates
      dx = longint'(px) - longint'(cx);
      dy = longint'(py) - longint'(cy);
      res.x = clamp_coord(scale_q30(dx, cs) - scale_q30(dy, sn) + longint'(cx));
      res.y = clamp_coord(scale_q30(dx, sn) + scale_q30(dy, cs) + longint'(cy));
      return res;
    endfunction

    function void note_input(logic [IN_W-1:0] beat, logic cw);
      awaited_points.push_back(rotate_about_centre(
        beat[0*CW_BITS +: CW_BITS], beat[1*CW_BITS +: CW_BITS],
        beat[2*CW_BITS +: CW_BITS], beat[3*CW_BITS +: CW_BITS],
        beat[4*CW_BITS +: ANG_BITS], cw));
    endfunction

    function void check_result(logic [OUT_W-1:0] beat);
      point_t want;
      coord_t got_x;
      coord_t got_y;
      got_x = beat[0 +: CW_BITS];
      got_y = beat[CW_BITS +: CW_BITS];
      results_seen++;
      if (awaited_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: (%0d, %0d) arrived with nothing awaited",
                   results_seen, got_x, got_y);
      end else begin
        want = awaited_points.pop_front();
        if (got_x !== want.x || got_y !== want.y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected (%0d, %0d), got (%0d, %0d)",
                     results_seen, want.x, want.y, got_x, got_y);
        end
      end
    endfunction

    function int unsigned pending();
      return awaited_points.size();
    endfunction

    function int unsigned failures();
      return mismatches + awaited_points.size();
    endfunction
  endclass

  logic             clk_i           = 1'b0;
  logic             rst_ni;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [IN_W-1:0]  s_axis_tdata_i  = '0;
  logic             s_axis_tuser_i  = 1'b0;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata_o;

  rotation_scoreboard book = new;
  int unsigned        burst_left = 0;

  vector_rotate_about_point u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    // point_x, point_y, center_x, center_y, angle_units, zero fill
    .s_axis_tdata_i  (s_axis_tdata_i),
    // turn_clockwise
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    // rotated_x, rotated_y
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // handshakes are sampled mid-cycle, when every input has settled
  always @(negedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      book.note_input(s_axis_tdata_i, s_axis_tuser_i);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      book.check_result(m_axis_tdata_o);
  end

  // offer one point, opening a new burst after a random gap when one runs out
  task automatic offer_point(input coord_t px, py, cx, cy, input angle_t ang,
                             input logic cw);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(IN_W - 4 * CW_BITS - ANG_BITS){1'b0}}, ang, cy, cx, py, px};
    s_axis_tuser_i  <= cw;
    do @(negedge clk_i); while (!s_axis_tready_o);
    @(posedge clk_i);
  endtask

  // stop offering and wait for every awaited point to come back
  task automatic drain_points();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (book.pending() != 0);
  endtask

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 5))
      0: pick_coord = coord_t'($urandom);
      1: pick_coord = COORD_MAX - coord_t'($urandom_range(0, 255));
      2: pick_coord = COORD_MIN + coord_t'($urandom_range(0, 255));
      3: pick_coord = coord_t'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      default: pick_coord = coord_t'(int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
    endcase
  endfunction

  function automatic angle_t pick_angle();
    case ($urandom_range(0, 9))
      // around multiples of a quarter turn
      0: pick_angle = angle_t'((int'($urandom_range(0, 8)) - 4) * int'(QUARTER)
                               + int'($urandom_range(0, 2)) - 1);
      // whole field, beyond a full turn too
      1: pick_angle = angle_t'($urandom);
      default: pick_angle = angle_t'(int'($urandom_range(0, 2 * TURN)) - int'(TURN));
    endcase
  endfunction

  // receiver: phases of steady, sparse, dense and periodic ready, one long hold-off
  initial begin : receiver
    int unsigned tick;
    int unsigned mode;
    int unsigned span;
    tick = 0;
    wait (rst_ni === 1'b1);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      repeat (span) begin
        @(posedge clk_i);
        tick++;
        if (tick == HOLD_AT) begin
          m_axis_tready_i <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
        end
        case (mode)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready_i <= ((tick % 3) != 0);
        endcase
      end
    end
  end

  // run limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int n;
    // reset goes low at time zero so the asynchronous reset takes effect at once
    rst_ni <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes of the coordinates, overflow of the offset and of the sum
    offer_point(32'sh0, 32'sh0, 32'sh0, 32'sh0, 18'sd0, 1'b1);
    offer_point(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 18'sd0, 1'b1);
    offer_point(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, angle_t'(QUARTER), 1'b0);
    offer_point(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 18'sd11520, 1'b1);
    offer_point(COORD_MIN, COORD_MAX, 32'sh0, 32'sh0, -18'sd11520, 1'b0);
    offer_point(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 18'sd12345, 1'b1);
    // quadrant edges, half and full turns, both directions
    offer_point(32'sh0005_0000, 32'sh0003_0000, 32'sh0001_0000, -32'sh0002_0000,
                angle_t'(QUARTER), 1'b1);
    offer_point(32'sh0005_0000, 32'sh0003_0000, 32'sh0001_0000, -32'sh0002_0000,
                angle_t'(QUARTER + 1), 1'b0);
    offer_point(32'sh0005_0000, 32'sh0003_0000, 32'sh0001_0000, -32'sh0002_0000,
                angle_t'(-QUARTER), 1'b1);
    offer_point(32'sh0005_0000, 32'sh0003_0000, 32'sh0001_0000, -32'sh0002_0000,
                angle_t'(-QUARTER - 1), 1'b0);
    offer_point(32'sh0005_0000, 32'sh0003_0000, 32'sh0001_0000, -32'sh0002_0000,
                angle_t'(HALF), 1'b1);
    offer_point(32'sh0005_0000, 32'sh0003_0000, 32'sh0001_0000, -32'sh0002_0000,
                angle_t'(-HALF), 1'b0);
    offer_point(32'sh0005_0000, 32'sh0003_0000, 32'sh0001_0000, -32'sh0002_0000,
                angle_t'(HALF - 1), 1'b1);
    offer_point(32'sh0005_0000, 32'sh0003_0000, 32'sh0001_0000, -32'sh0002_0000,
                angle_t'(TURN), 1'b1);
    offer_point(32'sh0005_0000, 32'sh0003_0000, 32'sh0001_0000, -32'sh0002_0000,
                angle_t'(-TURN), 1'b0);
    offer_point(32'sh0005_0000, 32'sh0003_0000, 32'sh0001_0000, -32'sh0002_0000,
                18'sd1, 1'b1);
    offer_point(32'sh0005_0000, 32'sh0003_0000, 32'sh0001_0000, -32'sh0002_0000,
                -18'sd1, 1'b0);
    // angles beyond a full turn wrap round
    offer_point(32'sh0005_0000, 32'sh0003_0000, 32'sh0001_0000, -32'sh0002_0000,
                18'sh1ffff, 1'b1);
    offer_point(32'sh0005_0000, 32'sh0003_0000, 32'sh0001_0000, -32'sh0002_0000,
                18'sh20000, 1'b0);
    offer_point(32'sh0005_0000, 32'sh0003_0000, 32'sh0001_0000, -32'sh0002_0000,
                18'sh20000, 1'b1);
    offer_point(-32'sh0040_8000, 32'sh0123_4567, 32'sh0002_0000, 32'sh0003_0000,
                18'sd100000, 1'b0);
    offer_point(-32'sh0040_8000, 32'sh0123_4567, 32'sh0002_0000, 32'sh0003_0000,
                -18'sd100000, 1'b1);
    drain_points();

    // random points, with one full drain half way
    for (n = 0; n < RANDOM_POINTS; n++) begin
      if (n == RANDOM_POINTS / 2) drain_points();
      offer_point(pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_angle(),
                  1'($urandom_range(0, 1)));
    end
    drain_points();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (book.failures() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
